// ===== rtl/lgba_pkg.sv =====
package lgba_pkg;

  // Number of LED groups: start, stop and status.
  localparam int unsigned GROUPS = 3;

  // Brightness and timing constants.
  localparam logic [7:0]  LEVEL_MAX         = 8'd255;
  localparam logic [7:0]  LEVEL_MIN         = 8'd0;
  localparam logic [15:0] STEP_INTERVAL_RST = 16'd10;

  // Register map, indexed by word address.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [1:0]  REG_START_MODE    = 2'd0;
  localparam logic [1:0]  REG_STOP_MODE     = 2'd1;
  localparam logic [1:0]  REG_STATUS_MODE   = 2'd2;
  localparam logic [1:0]  REG_STEP_INTERVAL = 2'd3;

  // Group display modes.
  typedef enum logic [2:0] {
    MODE_OFF           = 3'd0,
    MODE_RED           = 3'd1,
    MODE_GREEN         = 3'd2,
    MODE_BLUE          = 3'd3,
    MODE_BREATHE_RED   = 3'd4,
    MODE_BREATHE_GREEN = 3'd5,
    MODE_BREATHE_BLUE  = 3'd6,
    MODE_RAINBOW       = 3'd7
  } mode_t;

  // One RGB color.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

// ===== rtl/lgba_group.sv =====
// One LED group: brightness ramp state, step timer and the color it shows.
// The color register doubles as the group's part of the result register.
module lgba_group (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  lgba_pkg::mode_t  mode,
  input  logic [15:0]      step_interval,
  input  logic [31:0]      now_ms,
  output lgba_pkg::rgb_t   colour
);

  logic [7:0]      level_r, level_nxt;
  logic            falling_r, falling_nxt;
  logic [31:0]     last_r, last_nxt;
  lgba_pkg::rgb_t  colour_r, colour_nxt;

  logic            breathing;
  logic            due;
  logic [31:0]     elapsed;
  logic [7:0]      level_step;
  logic [7:0]      level_shown;

  // Interval test with wrapping time difference.
  assign elapsed   = now_ms - last_r;
  assign due       = (elapsed >= {16'd0, step_interval});
  assign breathing = (mode == lgba_pkg::MODE_BREATHE_RED) ||
                     (mode == lgba_pkg::MODE_BREATHE_GREEN) ||
                     (mode == lgba_pkg::MODE_BREATHE_BLUE);

  // Brightness ramp with turning points at full and at zero.
  always_comb begin
    level_step  = falling_r ? (level_r - 8'd1) : (level_r + 8'd1);
    level_nxt   = level_r;
    falling_nxt = falling_r;
    last_nxt    = last_r;
    if (breathing && due) begin
      level_nxt = level_step;
      last_nxt  = now_ms;
      if (level_step == lgba_pkg::LEVEL_MAX) begin
        falling_nxt = 1'b1;
      end
      if (level_step == lgba_pkg::LEVEL_MIN) begin
        falling_nxt = 1'b0;
      end
    end
    level_shown = level_nxt;
  end

  // Color selection; rainbow keeps the color shown last.
  always_comb begin
    colour_nxt = colour_r;
    unique case (mode)
      lgba_pkg::MODE_OFF:           colour_nxt = '0;
      lgba_pkg::MODE_RED:           colour_nxt = '{red: 8'hFF, green: 8'h00, blue: 8'h00};
      lgba_pkg::MODE_GREEN:         colour_nxt = '{red: 8'h00, green: 8'hFF, blue: 8'h00};
      lgba_pkg::MODE_BLUE:          colour_nxt = '{red: 8'h00, green: 8'h00, blue: 8'hFF};
      lgba_pkg::MODE_BREATHE_RED:   colour_nxt = '{red: level_shown, green: 8'h00, blue: 8'h00};
      lgba_pkg::MODE_BREATHE_GREEN: colour_nxt = '{red: 8'h00, green: level_shown, blue: 8'h00};
      lgba_pkg::MODE_BREATHE_BLUE:  colour_nxt = '{red: 8'h00, green: 8'h00, blue: level_shown};
      lgba_pkg::MODE_RAINBOW:       colour_nxt = colour_r;
      default:                      colour_nxt = colour_r;
    endcase
  end

  // State advances only when an input transfer is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= '0;
      falling_r <= 1'b0;
      last_r    <= '0;
      colour_r  <= '0;
    end else if (step_en) begin
      level_r   <= level_nxt;
      falling_r <= falling_nxt;
      last_r    <= last_nxt;
      colour_r  <= colour_nxt;
    end
  end

  assign colour = colour_r;

endmodule

// ===== rtl/led_group_breathing_animator.sv =====
// LED group breathing animator. Each input transfer carries the current
// millisecond time and produces one result transfer with the RGB color of
// the start, stop and status groups. Throughput is one item per clock cycle
// and the result is registered: the per-group interval compare and brightness
// step sit between the input port and the result register, and the next
// item is taken while a result still waits, as long as out_ready is high.
// Modes are set through the APB port: word 0 start, 1 stop, 2 status
// (0 off, 1-3 solid red/green/blue, 4-6 breathing red/green/blue, 7 hold),
// word 3 the breathing step interval in milliseconds (reset 10).
module led_group_breathing_animator (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [lgba_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_now_ms,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_start_red,
  output logic [7:0]  out_start_green,
  output logic [7:0]  out_start_blue,
  output logic [7:0]  out_stop_red,
  output logic [7:0]  out_stop_green,
  output logic [7:0]  out_stop_blue,
  output logic [7:0]  out_status_red,
  output logic [7:0]  out_status_green,
  output logic [7:0]  out_status_blue
);

  lgba_pkg::mode_t  start_mode_r, stop_mode_r, status_mode_r;
  logic [15:0]      step_interval_r;
  logic             out_valid_r, out_valid_nxt;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;
  logic             in_xfer;
  lgba_pkg::rgb_t   start_rgb, stop_rgb, status_rgb;

  // Configuration write and read-back.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_mode_r    <= lgba_pkg::MODE_OFF;
      stop_mode_r     <= lgba_pkg::MODE_OFF;
      status_mode_r   <= lgba_pkg::MODE_OFF;
      step_interval_r <= lgba_pkg::STEP_INTERVAL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lgba_pkg::REG_START_MODE:    start_mode_r    <= lgba_pkg::mode_t'(cfg_pwdata[2:0]);
        lgba_pkg::REG_STOP_MODE:     stop_mode_r     <= lgba_pkg::mode_t'(cfg_pwdata[2:0]);
        lgba_pkg::REG_STATUS_MODE:   status_mode_r   <= lgba_pkg::mode_t'(cfg_pwdata[2:0]);
        lgba_pkg::REG_STEP_INTERVAL: step_interval_r <= cfg_pwdata[15:0];
        default:                     step_interval_r <= step_interval_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      lgba_pkg::REG_START_MODE:    cfg_prdata = {29'd0, start_mode_r};
      lgba_pkg::REG_STOP_MODE:     cfg_prdata = {29'd0, stop_mode_r};
      lgba_pkg::REG_STATUS_MODE:   cfg_prdata = {29'd0, status_mode_r};
      lgba_pkg::REG_STEP_INTERVAL: cfg_prdata = {16'd0, step_interval_r};
      default:                     cfg_prdata = '0;
    endcase
  end

  // Handshake: a new transfer is taken whenever the result slot frees up.
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // One ramp per group, all stepping on the same transfer.
  lgba_group u_start (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (in_xfer),
    .mode          (start_mode_r),
    .step_interval (step_interval_r),
    .now_ms        (in_now_ms),
    .colour        (start_rgb)
  );

  lgba_group u_stop (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (in_xfer),
    .mode          (stop_mode_r),
    .step_interval (step_interval_r),
    .now_ms        (in_now_ms),
    .colour        (stop_rgb)
  );

  lgba_group u_status (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (in_xfer),
    .mode          (status_mode_r),
    .step_interval (step_interval_r),
    .now_ms        (in_now_ms),
    .colour        (status_rgb)
  );

  assign out_start_red    = start_rgb.red;
  assign out_start_green  = start_rgb.green;
  assign out_start_blue   = start_rgb.blue;
  assign out_stop_red     = stop_rgb.red;
  assign out_stop_green   = stop_rgb.green;
  assign out_stop_blue    = stop_rgb.blue;
  assign out_status_red   = status_rgb.red;
  assign out_status_green = status_rgb.green;
  assign out_status_blue  = status_rgb.blue;

endmodule

// ===== tb/lgba_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration port and both channels of the LED group animator.
// It tracks the register writes, predicts the colors of every input transfer
// and compares each result transfer with the oldest prediction.
module lgba_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic                            cfg_pready,
  input  logic [lgba_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [31:0]                     in_now_ms,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [7:0]                      out_start_red,
  input  logic [7:0]                      out_start_green,
  input  logic [7:0]                      out_start_blue,
  input  logic [7:0]                      out_stop_red,
  input  logic [7:0]                      out_stop_green,
  input  logic [7:0]                      out_stop_blue,
  input  logic [7:0]                      out_status_red,
  input  logic [7:0]                      out_status_green,
  input  logic [7:0]                      out_status_blue,
  output int unsigned                     error_count,
  output int unsigned                     colors_pending
);

  // One result: the color of each group, index 0 start, 1 stop, 2 status.
  typedef lgba_pkg::rgb_t [lgba_pkg::GROUPS-1:0] frame_t;

  // Shadow of the configuration registers.
  lgba_pkg::mode_t group_mode [lgba_pkg::GROUPS];
  logic [15:0]     step_ms;

  // Per-group animation state.
  logic [7:0]      level        [lgba_pkg::GROUPS];
  logic            falling      [lgba_pkg::GROUPS];
  logic [31:0]     last_step_ms [lgba_pkg::GROUPS];
  lgba_pkg::rgb_t  held         [lgba_pkg::GROUPS];

  // Colors predicted for input transfers whose results have not arrived yet.
  frame_t          color_q [$];

  string           group_tag [3];
  string           chan_tag  [3];

  initial begin
    group_tag[0] = "start";
    group_tag[1] = "stop";
    group_tag[2] = "status";
    chan_tag[0]  = "red";
    chan_tag[1]  = "green";
    chan_tag[2]  = "blue";
  end

  // Steps the brightness of one group once its interval has passed, with
  // the elapsed time taken modulo 2^32. It turns around at full and at zero.
  function automatic logic [7:0] breathe_level(int g, logic [31:0] now_ms);
    if (now_ms - last_step_ms[g] >= {16'd0, step_ms}) begin
      last_step_ms[g] = now_ms;
      if (falling[g]) begin
        level[g] = level[g] - 8'd1;
      end else begin
        level[g] = level[g] + 8'd1;
      end
      if (level[g] == lgba_pkg::LEVEL_MAX) begin
        falling[g] = 1'b1;
      end
      if (level[g] == lgba_pkg::LEVEL_MIN) begin
        falling[g] = 1'b0;
      end
    end
    return level[g];
  endfunction

  // Colors of all groups for one animation call. Rainbow keeps the last
  // color; every other mode also stores what it shows.
  function automatic frame_t predict_colors(logic [31:0] now_ms);
    frame_t         frame;
    lgba_pkg::rgb_t c;
    for (int g = 0; g < lgba_pkg::GROUPS; g++) begin
      c = held[g];
      case (group_mode[g])
        lgba_pkg::MODE_OFF: begin
          c = '0;
        end
        lgba_pkg::MODE_RED: begin
          c = {lgba_pkg::LEVEL_MAX, lgba_pkg::LEVEL_MIN, lgba_pkg::LEVEL_MIN};
        end
        lgba_pkg::MODE_GREEN: begin
          c = {lgba_pkg::LEVEL_MIN, lgba_pkg::LEVEL_MAX, lgba_pkg::LEVEL_MIN};
        end
        lgba_pkg::MODE_BLUE: begin
          c = {lgba_pkg::LEVEL_MIN, lgba_pkg::LEVEL_MIN, lgba_pkg::LEVEL_MAX};
        end
        lgba_pkg::MODE_BREATHE_RED: begin
          c = '0;
          c.red = breathe_level(g, now_ms);
        end
        lgba_pkg::MODE_BREATHE_GREEN: begin
          c = '0;
          c.green = breathe_level(g, now_ms);
        end
        lgba_pkg::MODE_BREATHE_BLUE: begin
          c = '0;
          c.blue = breathe_level(g, now_ms);
        end
        default: begin
        end
      endcase
      held[g]  = c;
      frame[g] = c;
    end
    return frame;
  endfunction

  // Register writes, prediction on each input transfer and comparison on
  // each result transfer.
  always @(posedge clk) begin
    frame_t want;
    frame_t got;
    if (!rst_n) begin
      for (int g = 0; g < lgba_pkg::GROUPS; g++) begin
        group_mode[g]   = lgba_pkg::MODE_OFF;
        level[g]        = lgba_pkg::LEVEL_MIN;
        falling[g]      = 1'b0;
        last_step_ms[g] = '0;
        held[g]         = '0;
      end
      step_ms = lgba_pkg::STEP_INTERVAL_RST;
      color_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[lgba_pkg::CFG_ADDR_W-1:2])
          lgba_pkg::REG_START_MODE:    group_mode[0] = lgba_pkg::mode_t'(cfg_pwdata[2:0]);
          lgba_pkg::REG_STOP_MODE:     group_mode[1] = lgba_pkg::mode_t'(cfg_pwdata[2:0]);
          lgba_pkg::REG_STATUS_MODE:   group_mode[2] = lgba_pkg::mode_t'(cfg_pwdata[2:0]);
          lgba_pkg::REG_STEP_INTERVAL: step_ms = cfg_pwdata[15:0];
          default: begin
          end
        endcase
      end

      if (in_valid && in_ready) begin
        color_q.push_back(predict_colors(in_now_ms));
      end

      if (out_valid && out_ready) begin
        got[0] = {out_start_red, out_start_green, out_start_blue};
        got[1] = {out_stop_red, out_stop_green, out_stop_blue};
        got[2] = {out_status_red, out_status_green, out_status_blue};
        if (color_q.size() == 0) begin
          error_count = error_count + 1;
          if (error_count <= 10) begin
            $display("%0t: result transfer with no prediction pending, got %h", $time, got);
          end
        end else begin
          want = color_q.pop_front();
          for (int g = 0; g < lgba_pkg::GROUPS; g++) begin
            for (int ch = 0; ch < 3; ch++) begin
              if (got[g][23-8*ch -: 8] !== want[g][23-8*ch -: 8]) begin
                error_count = error_count + 1;
                if (error_count <= 10) begin
                  $display("%0t: %s %s expected %0d, got %0d", $time, group_tag[g],
                           chan_tag[ch], want[g][23-8*ch -: 8], got[g][23-8*ch -: 8]);
                end
              end
            end
          end
        end
      end
    end
    colors_pending = color_q.size();
  end

endmodule

// ===== tb/tb_led_group_breathing_animator.sv =====
`timescale 1ns / 1ps

module tb_led_group_breathing_animator;

  localparam int RANDOM_ITEMS = 640;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [lgba_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_now_ms;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_start_red;
  logic [7:0]  out_start_green;
  logic [7:0]  out_start_blue;
  logic [7:0]  out_stop_red;
  logic [7:0]  out_stop_green;
  logic [7:0]  out_stop_blue;
  logic [7:0]  out_status_red;
  logic [7:0]  out_status_green;
  logic [7:0]  out_status_blue;

  int unsigned error_count;
  int unsigned colors_pending;
  int          cycle_count;
  int          send_idle_pct;
  int          stall_pct;

  led_group_breathing_animator dut (.*);

  lgba_checker checker_i (.*);

  // Clock with a 4 ns period.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("led_group_breathing_animator verification failed");
    $finish;
  end

  // The result side stalls at random when the current phase asks for it.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  // Writes one register over APB once every predicted result has arrived.
  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    in_valid = 1'b0;
    while (colors_pending != 0) @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {index, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Sets the three group modes; the unused upper data bits are random.
  task automatic set_modes(input lgba_pkg::mode_t start_m, input lgba_pkg::mode_t stop_m,
                           input lgba_pkg::mode_t status_m);
    write_reg(lgba_pkg::REG_START_MODE, {$urandom} & 32'hFFFF_FFF8 | start_m);
    write_reg(lgba_pkg::REG_STOP_MODE, {$urandom} & 32'hFFFF_FFF8 | stop_m);
    write_reg(lgba_pkg::REG_STATUS_MODE, {$urandom} & 32'hFFFF_FFF8 | status_m);
  endtask

  task automatic set_interval(input logic [15:0] step);
    write_reg(lgba_pkg::REG_STEP_INTERVAL, {$urandom} & 32'hFFFF_0000 | step);
  endtask

  // One animation call: optional idle cycles, then hold valid until the transfer.
  task automatic send_time(input logic [31:0] now_ms);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    in_now_ms = now_ms;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic lgba_pkg::mode_t pick_mode();
    if ($urandom_range(99) < 80) begin
      return lgba_pkg::mode_t'($urandom_range(4, 6));
    end
    return lgba_pkg::mode_t'($urandom_range(0, 7));
  endfunction

  initial begin
    int          seg_end;
    int          phase;
    int unsigned step;
    logic [31:0] now_ms;

    cycle_count   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    rst_n         = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    in_valid      = 1'b0;
    in_now_ms     = '0;
    out_ready     = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Reset configuration: every group off, time at both extremes.
    send_time(32'h0000_0000);
    send_time(32'hFFFF_FFFF);

    // Breathing with the reset interval, across the wrap of the time counter.
    set_modes(lgba_pkg::MODE_BREATHE_RED, lgba_pkg::MODE_BREATHE_GREEN,
              lgba_pkg::MODE_BREATHE_BLUE);
    send_time(32'd5);
    send_time(32'hFFFF_FFF0);
    send_time(32'd2);
    send_time(32'd5);

    // A zero interval steps on every call, even with the same time.
    set_interval(16'd0);
    send_time(32'd7);
    send_time(32'd7);
    send_time(32'd7);

    // Solid colors, then off and rainbow holding the solid colors.
    set_modes(lgba_pkg::MODE_RED, lgba_pkg::MODE_GREEN, lgba_pkg::MODE_BLUE);
    send_time(32'd100);
    set_modes(lgba_pkg::MODE_RAINBOW, lgba_pkg::MODE_OFF, lgba_pkg::MODE_RAINBOW);
    send_time(32'd200);
    send_time(32'd300);

    // The brightness survives mode changes; rainbow holds a breathing color.
    set_modes(lgba_pkg::MODE_BREATHE_GREEN, lgba_pkg::MODE_RAINBOW,
              lgba_pkg::MODE_BREATHE_RED);
    send_time(32'd301);
    set_modes(lgba_pkg::MODE_RAINBOW, lgba_pkg::MODE_BREATHE_BLUE, lgba_pkg::MODE_OFF);
    send_time(32'd302);

    // Largest interval: short gaps do not step, long ones do.
    set_interval(16'hFFFF);
    set_modes(lgba_pkg::MODE_BREATHE_BLUE, lgba_pkg::MODE_BREATHE_RED,
              lgba_pkg::MODE_BREATHE_GREEN);
    send_time(32'd303);
    send_time(32'h0001_0006);
    send_time(32'h8000_0000);

    // Random segments: new modes and interval per segment, mostly advancing
    // time past the interval so the brightness sweeps both turning points.
    now_ms  = $urandom;
    seg_end = 0;
    step    = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = n * 4 / RANDOM_ITEMS;
      if (n == seg_end) begin
        set_modes(pick_mode(), pick_mode(), pick_mode());
        case ($urandom_range(7))
          0:       step = 0;
          1:       step = 1;
          2:       step = 16'hFFFF;
          3:       step = $urandom_range(2, 16'hFFFE);
          default: step = $urandom_range(1, 20);
        endcase
        set_interval(step[15:0]);
        seg_end = n + $urandom_range(30, 70);
      end
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 57;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 57;
        end
        default: begin
          send_idle_pct = 32;
          stall_pct     = 32;
        end
      endcase
      if ($urandom_range(99) < 8) begin
        now_ms = $urandom;
      end else if ($urandom_range(99) < 90) begin
        now_ms = now_ms + $urandom_range(step, 2 * step + 1);
      end else begin
        now_ms = now_ms + $urandom_range(0, step);
      end
      send_time(now_ms);
    end

    // Let every result arrive, then watch a little longer for extras.
    in_valid      = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    while (colors_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("led_group_breathing_animator verification clean");
    end else begin
      $display("led_group_breathing_animator verification failed");
    end
    $finish;
  end

endmodule
